// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/crcrx_pkg.sv
// Types, constants and the CRC-16/MODBUS byte update for the request frame receiver.
// No dependencies; every other file in this block but assert_macros.svh imports it.
`timescale 1ns / 1ps

package crcrx_pkg;

  localparam int PAYLOAD_BYTES = 16;
  localparam int CNT_W         = 5;
  localparam int ADDR_WORDS    = 4;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  // byte position of the received CRC low byte within a frame
  localparam logic [CNT_W-1:0] CRC_LO_POS = CNT_W'(PAYLOAD_BYTES);

  typedef enum logic [1:0] {
    EV_CRC_GOOD = 2'd0,
    EV_CRC_BAD  = 2'd1,
    EV_TIMEOUT  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic       line_error;
    logic [7:0] rx_byte;
    logic       command;
  } item_t;

  typedef struct packed {
    event_kind_t                 kind;
    logic [ADDR_WORDS-1:0][15:0] addr;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crcrx_in_reg.sv
// Input register for received beats; releases a beat when the core advances.
// Depends on crcrx_pkg.
`timescale 1ns / 1ps

module crcrx_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  crcrx_pkg::item_t in_item,
  input  logic            advance,
  output logic            held_valid,
  output crcrx_pkg::item_t held_item
);
  import crcrx_pkg::*;

  logic held_valid_next;

  assign in_ready = !held_valid || advance;

  always_comb begin
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end else begin
      held_valid_next = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: hw/rtl/crcrx_core.sv
// Frame state: byte count, running CRC, address capture and idle tick counter.
// Depends on crcrx_pkg (crc16_byte, item and result types).
`timescale 1ns / 1ps

module crcrx_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               advance,
  input  crcrx_pkg::item_t   item,
  output logic               res_valid,
  output crcrx_pkg::result_t res
);
  import crcrx_pkg::*;

  logic [15:0]                 timeout_ticks;
  logic [CNT_W-1:0]            byte_count;
  logic [15:0]                 running_crc;
  logic [15:0]                 idle_ticks;
  logic [ADDR_WORDS-1:0][15:0] address_words;
  logic [7:0]                  crc_low_byte;

  logic [CNT_W-1:0]            byte_count_next;
  logic [15:0]                 running_crc_next;
  logic [15:0]                 idle_ticks_next;
  logic [ADDR_WORDS-1:0][15:0] address_words_next;
  logic [7:0]                  crc_low_byte_next;

  logic [15:0] limit;
  logic [15:0] ticks_inc;
  logic [1:0]  word_sel;

  assign limit     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign ticks_inc = (idle_ticks == TICKS_MAX) ? idle_ticks : idle_ticks + 16'd1;
  assign word_sel  = byte_count[3:2];

  always_comb begin
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    idle_ticks_next    = idle_ticks;
    address_words_next = address_words;
    crc_low_byte_next  = crc_low_byte;
    res_valid          = 1'b0;
    res.kind           = EV_CRC_GOOD;
    res.addr           = address_words;
    if (item.command) begin
      if (byte_count != '0) begin
        if (ticks_inc >= limit) begin
          // drop the partial frame
          byte_count_next  = '0;
          running_crc_next = CRC_INIT;
          idle_ticks_next  = '0;
          res_valid        = 1'b1;
          res.kind         = EV_TIMEOUT;
          res.addr         = '0;
        end else begin
          idle_ticks_next = ticks_inc;
        end
      end
    end else if (!item.line_error) begin
      if (byte_count < CRC_LO_POS) begin
        running_crc_next = crc16_byte(running_crc, item.rx_byte);
        // address bytes sit at offsets 0 and 1 of each 4-byte group
        if (!byte_count[1]) begin
          if (byte_count[0]) begin
            address_words_next[word_sel][15:8] = item.rx_byte;
          end else begin
            address_words_next[word_sel][7:0] = item.rx_byte;
          end
        end
        byte_count_next = byte_count + CNT_W'(1);
      end else if (byte_count == CRC_LO_POS) begin
        crc_low_byte_next = item.rx_byte;
        byte_count_next   = byte_count + CNT_W'(1);
      end else begin
        res_valid        = 1'b1;
        res.kind         = ({item.rx_byte, crc_low_byte} == running_crc) ? EV_CRC_GOOD
                                                                          : EV_CRC_BAD;
        byte_count_next  = '0;
        running_crc_next = CRC_INIT;
        idle_ticks_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      byte_count    <= '0;
      running_crc   <= CRC_INIT;
      idle_ticks    <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      if (advance) begin
        byte_count  <= byte_count_next;
        running_crc <= running_crc_next;
        idle_ticks  <= idle_ticks_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      address_words <= address_words_next;
      crc_low_byte  <= crc_low_byte_next;
    end
  end

endmodule

// File: hw/rtl/crcrx_out_reg.sv
// Result register between the core and the master-side stream.
// Depends on crcrx_pkg (result type).
`timescale 1ns / 1ps

module crcrx_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               held_valid,
  output logic               advance,
  input  logic               res_valid,
  input  crcrx_pkg::result_t res,
  output logic               out_valid,
  input  logic               out_ready,
  output crcrx_pkg::result_t out_res
);
  import crcrx_pkg::*;

  logic out_valid_next;

  // advance when a beat is held and the result slot is empty or drains this cycle
  assign advance = held_valid && (!out_valid || out_ready);

  always_comb begin
    if (advance) begin
      out_valid_next = res_valid;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// File: hw/rtl/crc16_request_frame_receiver.sv
// Top level of the CRC-16/MODBUS request frame receiver.
// Depends on crcrx_pkg, crcrx_in_reg, crcrx_core and crcrx_out_reg.
`timescale 1ns / 1ps

// Takes one beat per cycle while s_axis_tready is high: a received byte (tuser[0] low) or a
// timer tick (tuser[0] high), with tuser[1] flagging a line error that drops the byte. Each beat
// waits in the input register while the core's combinational unrolled CRC byte update runs; the
// result then passes through the output register to the master side. A result beat stalled on the
// master side holds the input beat behind it. An 18-byte frame yields one beat on the master
// side: tuser is the event kind (0 good CRC, 1 bad CRC, 2 timeout) and tdata carries the four
// addresses, which are zero for a timeout. The timeout register is written through
// cfg_wr_en / cfg_wr_data, resets to 1000 ticks and treats 0 as 1; write it only while the
// block is idle.
module crc16_request_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // command, line_error
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // address_0, address_1, address_2, address_3
  output logic [1:0]  m_axis_tuser    // event_kind
);
  import crcrx_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.command    = s_axis_tuser[0];
  assign in_item.line_error = s_axis_tuser[1];
  assign in_item.rx_byte    = s_axis_tdata;

  crcrx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  crcrx_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (held_item),
    .res_valid   (res_valid),
    .res         (res)
  );

  crcrx_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res)
  );

  assign m_axis_tdata = out_res.addr;
  assign m_axis_tuser = out_res.kind;

endmodule

// File: hw/rtl/crcrx_checker.sv
// Port-level checks for the request frame receiver, bound to the top level.
// Depends on crcrx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crcrx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import crcrx_pkg::*;

  logic        out_stall;
  logic [65:0] out_beat;
  logic        kind_ok;
  logic        out_timeout;

  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_beat    = {m_axis_tuser, m_axis_tdata};
  assign kind_ok     = (m_axis_tuser == EV_CRC_GOOD) || (m_axis_tuser == EV_CRC_BAD) ||
                       (m_axis_tuser == EV_TIMEOUT);
  assign out_timeout = m_axis_tvalid && (m_axis_tuser == EV_TIMEOUT);

  // a stalled result beat holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_stall |=> m_axis_tvalid && $stable(out_beat))

  `ASSERT_CLK_RST(a_kind_legal, clk, rst, m_axis_tvalid |-> kind_ok)

  // a timeout beat carries no addresses
  `ASSERT_CLK_RST(a_timeout_zero, clk, rst, out_timeout |-> m_axis_tdata == 64'd0)

  `ASSERT_CLK(a_reset_idle, clk, rst |=> !m_axis_tvalid)

  // the input side is never blocked while nothing waits on the output
  `ASSERT_CLK_RST(a_ready_free, clk, rst, !m_axis_tvalid |-> s_axis_tready)

endmodule

bind crc16_request_frame_receiver crcrx_checker u_crcrx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_top.sv
// Self-checking bench for crc16_request_frame_receiver: directed frames, then random traffic.
// Depends on crcrx_pkg and the receiver RTL; predicts each event from its own frame tracker.
`timescale 1ns / 1ps

module tb_top;
  import crcrx_pkg::*;

  localparam bit CMD_BYTE = 1'b0;
  localparam bit CMD_TICK = 1'b1;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIRECTED = 25;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TIMEOUT} row_check_t;

  typedef struct {
    row_kind_t  kind;
    logic       cmd;
    logic [15:0] value;
    logic       err;
    row_check_t check;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // rx_byte
  logic [1:0]  s_axis_tuser = '0;   // command, line_error
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // address_0, address_1, address_2, address_3
  logic [1:0]  m_axis_tuser;        // event_kind

  crc16_request_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame tracker state
  logic [15:0] timeout_reg = TIMEOUT_RESET;
  logic [4:0]  frame_len = '0;
  logic [15:0] payload_crc = 16'hFFFF;
  logic [15:0] addr_word [ADDR_WORDS] = '{default: '0};
  logic [7:0]  crc_lo_seen = '0;
  logic [15:0] idle_count = '0;

  result_t pending_events [$];
  int      fail_count = 0;
  bit      quiet_src = 1'b0;
  bit      no_gap = 1'b0;
  int      beat_count = 0;
  bit      quiet_sink = 1'b0;
  int      stall_left = 0;
  int      sink_cycles = 0;

  row_t directed_rows [N_DIRECTED] = '{
    '{ROW_BEAT, CMD_TICK, 16'h0000, 1'b0, EXP_NONE},    // tick with no partial frame
    '{ROW_BEAT, CMD_BYTE, 16'h00FF, 1'b1, EXP_NONE},    // errored byte, drop
    '{ROW_BEAT, CMD_BYTE, 16'h0000, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0000, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h005A, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h00A5, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h00FF, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h00FF, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0033, 1'b1, EXP_NONE},    // errored byte inside a frame
    '{ROW_BEAT, CMD_BYTE, 16'h0001, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0080, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h00FE, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h007F, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0033, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h00CC, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0080, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0001, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h00C3, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h003C, 1'b0, EXP_MODEL},
    '{ROW_BEAT, CMD_BYTE, 16'h0000, 1'b0, EXP_MODEL},   // received CRC, low byte
    '{ROW_BEAT, CMD_BYTE, 16'h0000, 1'b0, EXP_MODEL},   // received CRC, high byte
    '{ROW_CFG,  CMD_BYTE, 16'h0000, 1'b0, EXP_NONE},    // zero timeout acts as one tick
    '{ROW_BEAT, CMD_BYTE, 16'h0080, 1'b0, EXP_NONE},
    '{ROW_BEAT, CMD_TICK, 16'h0000, 1'b0, EXP_TIMEOUT},
    '{ROW_BEAT, CMD_TICK, 16'h0000, 1'b0, EXP_NONE}
  };

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      if (acc[0]) acc = {1'b0, acc[15:1]} ^ 16'hA001;
      else acc = {1'b0, acc[15:1]};
    end
    return acc;
  endfunction

  function automatic item_t make_item(input logic cmd, input logic [7:0] b, input logic err);
    item_t it;
    it.command = cmd;
    it.rx_byte = b;
    it.line_error = err;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic int tick_limit();
    return (timeout_reg == 16'd0) ? 1 : int'(timeout_reg);
  endfunction

  function automatic void clear_frame();
    frame_len = '0;
    payload_crc = 16'hFFFF;
    idle_count = '0;
  endfunction

  // Advance the frame tracker by one accepted beat; returns 1 when an event is due.
  function automatic bit next_event(input item_t it, output result_t ev);
    logic [15:0] rx_crc;
    ev = '0;
    if (it.command == CMD_TICK) begin
      if (frame_len == 0) return 1'b0;
      if (idle_count != TICKS_MAX) idle_count = idle_count + 16'd1;
      if (int'(idle_count) >= tick_limit()) begin
        clear_frame();
        ev.kind = EV_TIMEOUT;
        return 1'b1;
      end
      return 1'b0;
    end
    if (it.line_error) return 1'b0;
    if (frame_len < PAYLOAD_BYTES) begin
      payload_crc = crc_step(payload_crc, it.rx_byte);
      // address bytes sit at positions 0/1 of every group of four
      if (!frame_len[1]) begin
        if (frame_len[0]) addr_word[frame_len[3:2]][15:8] = it.rx_byte;
        else addr_word[frame_len[3:2]][7:0] = it.rx_byte;
      end
      frame_len = frame_len + 5'd1;
      return 1'b0;
    end
    if (frame_len == PAYLOAD_BYTES) begin
      crc_lo_seen = it.rx_byte;
      frame_len = frame_len + 5'd1;
      return 1'b0;
    end
    rx_crc = {it.rx_byte, crc_lo_seen};
    ev.kind = (rx_crc == payload_crc) ? EV_CRC_GOOD : EV_CRC_BAD;
    for (int i = 0; i < ADDR_WORDS; i++) ev.addr[i] = addr_word[i];
    clear_frame();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gap || quiet_src) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_beat(input item_t it, input row_check_t check = EXP_MODEL);
    int gap;
    result_t ev;
    bit due;
    gap = pick_gap();
    beat_count++;
    if (beat_count % 40 == 0) quiet_src = ($urandom_range(0, 3) == 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it.rx_byte;
    s_axis_tuser <= {it.line_error, it.command};
    do @(posedge clk); while (!s_axis_tready);
    due = next_event(it, ev);
    case (check)
      EXP_MODEL: begin
        if (due) pending_events.push_back(ev);
      end
      EXP_TIMEOUT: begin
        ev = '0;
        ev.kind = EV_TIMEOUT;
        pending_events.push_back(ev);
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timeout_reg = value;
  endtask

  // Bring the receiver back to a frame boundary: tick it out when the limit is short,
  // otherwise fill the frame up.
  task automatic resync();
    while (frame_len != 0) begin
      if (tick_limit() <= 64) send_beat(make_item(CMD_TICK, 8'($urandom), 1'($urandom)));
      else send_beat(make_item(CMD_BYTE, rand_byte(), 1'b0));
    end
  endtask

  // Open a frame and tick it out back to back.
  task automatic tick_out();
    resync();
    send_beat(make_item(CMD_BYTE, rand_byte(), 1'b0));
    no_gap = 1'b1;
    while (frame_len != 0) send_beat(make_item(CMD_TICK, 8'($urandom), 1'($urandom)));
    no_gap = 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] tmo, input int n_items);
    int sent;
    int pick;
    int n;
    int r;
    logic [7:0] payload [PAYLOAD_BYTES];
    logic [15:0] crc;
    logic [7:0] b;
    write_timeout(tmo);
    sent = 0;
    while (sent < n_items) begin
      resync();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        crc = 16'hFFFF;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          payload[i] = rand_byte();
          crc = crc_step(crc, payload[i]);
        end
        if (pick >= 60) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        for (int i = 0; i < PAYLOAD_BYTES + 2; i++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            send_beat(make_item(CMD_BYTE, 8'($urandom), 1'b1));
            sent++;
          end else if (r < 16) begin
            repeat ($urandom_range(1, 3)) begin
              send_beat(make_item(CMD_TICK, 8'($urandom), 1'($urandom)));
              sent++;
            end
          end
          if (i < PAYLOAD_BYTES) b = payload[i];
          else if (i == PAYLOAD_BYTES) b = crc[7:0];
          else b = crc[15:8];
          send_beat(make_item(CMD_BYTE, b, 1'b0));
          sent++;
        end
      end else if (pick < 90) begin
        n = $urandom_range(1, PAYLOAD_BYTES + 1);
        repeat (n) send_beat(make_item(CMD_BYTE, rand_byte(), 1'b0));
        sent += n;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(make_item(1'($urandom), 8'($urandom), 1'($urandom)));
        sent += n;
      end
    end
    // tick out only where the limit is short; long limits would take thousands of ticks
    if (tick_limit() <= 64) tick_out();
  endtask

  // Sink side: random stalls, some long, with quiet stretches.
  always @(posedge clk) begin
    sink_cycles <= sink_cycles + 1;
    if (sink_cycles % 64 == 0) quiet_sink <= ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (quiet_sink || $urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: event_kind %0d, addresses %h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        for (int i = 0; i < ADDR_WORDS; i++) begin
          if (m_axis_tdata[16*i +: 16] !== want.addr[i]) begin
            $error("address_%0d: expected %h, actual %h", i, want.addr[i],
                   m_axis_tdata[16*i +: 16]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_timeout(directed_rows[i].value);
      else send_beat(make_item(directed_rows[i].cmd, directed_rows[i].value[7:0],
                               directed_rows[i].err), directed_rows[i].check);
    end
    run_phase(16'd1, 110);
    run_phase(16'($urandom_range(2, 40)), 130);
    run_phase(TIMEOUT_RESET, 110);
    run_phase(16'hFFFF, 100);
    run_phase(16'd0, 90);
    run_phase(16'($urandom_range(2, 12)), 130);
    wait_idle();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/crcrx_pkg.sv
hw/rtl/crcrx_in_reg.sv
hw/rtl/crcrx_core.sv
hw/rtl/crcrx_out_reg.sv
hw/rtl/crc16_request_frame_receiver.sv
hw/rtl/crcrx_checker.sv
tb/tb_top.sv
